[hw/rtl/lser_pkg.sv]
// ----------------------------------------------------------------------------
// lser_pkg
// shared types and constants for the led strip effect renderer
// ----------------------------------------------------------------------------
package lser_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ADV
  } lser_state_t;

  typedef enum logic [3:0] {
    EFF_FLOW        = 4'd0,
    EFF_METEOR      = 4'd1,
    EFF_DOUBLE      = 4'd2,
    EFF_BANDS       = 4'd3,
    EFF_BREATH      = 4'd4,
    EFF_YBEAT       = 4'd5,
    EFF_GFLOW       = 4'd6,
    EFF_PALETTE     = 4'd7,
    EFF_RBEAT       = 4'd8,
    EFF_RMETEOR     = 4'd9,
    EFF_YMETEOR     = 4'd10,
    EFF_GMETEOR     = 4'd11,
    EFF_CONST_R     = 4'd12,
    EFF_CONST_G     = 4'd13,
    EFF_CONST_B     = 4'd14,
    EFF_OFF         = 4'd15
  } lser_effect_t;

  localparam logic REG_EFFECT  = 1'b0;
  localparam logic REG_REFRESH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic start;    // load first pixel
    logic next;     // step to next pixel
    logic advance;  // advance phase of current effect
  } lser_cmd_t;

  typedef struct packed {
    logic last;     // current pixel is pixel 0
  } lser_sts_t;

  function automatic logic [23:0] band_colour(input logic [1:0] i);
    case (i)
      2'd0: band_colour = 24'h443300;
      2'd1: band_colour = 24'h005544;
      2'd2: band_colour = 24'h44333e;
      default: band_colour = 24'h330049;
    endcase
  endfunction

  function automatic logic [23:0] palette_colour(input logic [2:0] i);
    case (i)
      3'd0: palette_colour = 24'h440c0c;
      3'd1: palette_colour = 24'h4f2700;
      3'd2: palette_colour = 24'h443104;
      3'd3: palette_colour = 24'h294429;
      3'd4: palette_colour = 24'h243744;
      3'd5: palette_colour = 24'h172b3c;
      3'd6: palette_colour = 24'h341055;
      default: palette_colour = 24'h440c0c;
    endcase
  endfunction

endpackage

[hw/rtl/lser_ctrl.sv]
// ----------------------------------------------------------------------------
// lser_ctrl
// frame sequencer: tick counting, pixel emission, phase advance
// ----------------------------------------------------------------------------
module lser_ctrl import lser_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_paused,
  input  logic [7:0]  refresh_ticks,
  input  logic        out_taken,
  output logic        out_busy,
  output lser_cmd_t   cmd,
  input  lser_sts_t   sts
);

  lser_state_t state_r, state_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [7:0]  tick_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
    end
  end

  assign tick_inc = tick_r + 8'd1;

  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_r;
    cmd         = '0;
    in_stall    = 1'b1;
    out_busy    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !in_paused) begin
          if (tick_inc >= refresh_ticks) begin
            tick_nxt  = '0;
            cmd.start = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      ST_EMIT: begin
        out_busy = 1'b1;
        if (out_taken) begin
          if (sts.last) begin
            state_nxt = ST_ADV;
          end else begin
            cmd.next = 1'b1;
          end
        end
      end
      ST_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/lser_dp.sv]
// ----------------------------------------------------------------------------
// lser_dp
// pixel colour datapath and effect phase store
// ----------------------------------------------------------------------------
module lser_dp import lser_pkg::*; #(
  parameter int NUM_PIXELS   = 60,
  parameter int BRIGHT_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  effect_sel,
  input  lser_cmd_t   cmd,
  output lser_sts_t   sts,
  output logic [5:0]  pixel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  localparam int B1 = BRIGHT_STEPS + 1;
  localparam int B2 = BRIGHT_STEPS - 2;
  // divide by BRIGHT_STEPS as multiply by rounded-up reciprocal, exact for 15-bit products
  localparam int RECIP_SHIFT = 21;
  localparam logic [19:0] RECIP =
    20'(((2 ** RECIP_SHIFT) + BRIGHT_STEPS - 1) / BRIGHT_STEPS);

  logic [7:0] phase_r [12];
  logic [2:0] pal_r;
  logic [3:0] eff_r;
  logic [5:0] pix_r;
  logic [5:0] pmod_r;   // p % (B+1)
  logic [5:0] mdist_r;  // (p - ph) mod NUM_PIXELS
  logic [7:0] ph;
  logic [7:0] start_ph;

  // meteor phases always stay below NUM_PIXELS
  assign start_ph = (effect_sel < 4'd12) ? phase_r[effect_sel] : 8'd0;

  // pixel counters walk downward with the pixel position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      eff_r   <= effect_sel;
      pix_r   <= 6'(NUM_PIXELS - 1);
      pmod_r  <= 6'((NUM_PIXELS - 1) % B1);
      mdist_r <= 6'(NUM_PIXELS - 1) - start_ph[5:0];
    end else if (cmd.next) begin
      pix_r   <= pix_r - 6'd1;
      pmod_r  <= (pmod_r == 6'd0) ? 6'(B1 - 1) : pmod_r - 6'd1;
      mdist_r <= (mdist_r == 6'd0) ? 6'(NUM_PIXELS - 1) : mdist_r - 6'd1;
    end
  end

  assign ph = (eff_r < 4'd12) ? phase_r[eff_r] : 8'd0;
  assign sts.last = (pix_r == 6'd0);

  // step and base colour
  logic [23:0] base;
  logic [6:0]  step;
  logic        raw;
  logic [6:0]  fsum;
  logic [5:0]  band;

  always_comb begin
    base = 24'h0;
    step = '0;
    raw  = 1'b0;
    fsum = 7'(pmod_r) + 7'(ph);
    if (fsum >= 7'(B1)) fsum = fsum - 7'(B1);
    band = (pix_r >= 6'd40) ? pix_r - 6'd40 : pix_r;
    case (lser_effect_t'(eff_r))
      EFF_FLOW:  begin base = 24'h44333e; step = fsum; end
      EFF_GFLOW: begin base = 24'h295400; step = fsum; end
      EFF_METEOR: if (mdist_r < 6'd20) begin base = 24'h005544; step = 7'(mdist_r); end
      EFF_RMETEOR: if (mdist_r < 6'd8) begin base = 24'h880000; step = 7'(mdist_r); end
      EFF_YMETEOR: if (mdist_r < 6'd8) begin base = 24'h4A4A00; step = 7'(mdist_r); end
      EFF_GMETEOR: if (mdist_r < 6'd8) begin base = 24'h008800; step = 7'(mdist_r); end
      EFF_DOUBLE: begin
        if (mdist_r < 6'd20) begin
          base = 24'h005544; step = 7'(mdist_r);
        end else if (mdist_r >= 6'd30 && mdist_r < 6'd50) begin
          base = 24'h330049; step = 7'(mdist_r - 6'd30);
        end
      end
      EFF_BANDS: begin
        raw  = 1'b1;
        base = band_colour(ph[1:0] + ((band >= 6'd30) ? 2'd3 :
                                      (band >= 6'd20) ? 2'd2 :
                                      (band >= 6'd10) ? 2'd1 : 2'd0));
      end
      EFF_BREATH:  begin base = 24'h331144; step = 7'(ph); end
      EFF_PALETTE: begin base = palette_colour(pal_r); step = 7'(ph); end
      EFF_YBEAT: if (ph == 8'd0) begin base = 24'h4f4f00; step = 7'(B2); end
      EFF_RBEAT: if (ph == 8'd0) begin base = 24'h350505; step = 7'(B2); end
      EFF_CONST_R: begin base = 24'hFF0000; step = 7'd8; end
      EFF_CONST_G: begin base = 24'h00FF00; step = 7'd8; end
      EFF_CONST_B: begin base = 24'h0000FF; step = 7'd8; end
      default: base = 24'h0;
    endcase
  end

  function automatic logic [7:0] scale(input logic [7:0] c, input logic [6:0] s);
    logic [14:0] prod;
    logic [34:0] wide;
    logic [13:0] q;
    prod  = 15'(c) * 15'(s);
    wide  = 35'(prod) * 35'(RECIP);
    q     = wide[34:RECIP_SHIFT];
    scale = (q > 14'd255) ? 8'd255 : q[7:0];
  endfunction

  assign pixel_index = pix_r;
  assign red   = raw ? base[23:16] : scale(base[23:16], step);
  assign green = raw ? base[15:8]  : scale(base[15:8], step);
  assign blue  = raw ? base[7:0]   : scale(base[7:0], step);

  // phase advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) phase_r[i] <= '0;
      pal_r <= '0;
    end else if (cmd.advance && eff_r < 4'd12) begin
      case (lser_effect_t'(eff_r))
        EFF_FLOW, EFF_GFLOW:
          phase_r[eff_r] <= (ph == 8'(BRIGHT_STEPS - 1)) ? 8'd0 : ph + 8'd1;
        EFF_METEOR, EFF_DOUBLE, EFF_RMETEOR, EFF_YMETEOR, EFF_GMETEOR:
          phase_r[eff_r] <= (ph + 8'd2 >= 8'(NUM_PIXELS)) ?
                            ph + 8'd2 - 8'(NUM_PIXELS) : ph + 8'd2;
        EFF_BANDS: phase_r[eff_r] <= {6'd0, ph[1:0] + 2'd1};
        EFF_BREATH:
          phase_r[eff_r] <= (ph + 8'd2 >= 8'(B2)) ? ph + 8'd2 - 8'(B2) : ph + 8'd2;
        EFF_YBEAT, EFF_RBEAT: phase_r[eff_r] <= {7'd0, ~ph[0]};
        default: begin
          phase_r[eff_r] <= (ph + 8'd1 >= 8'(B2)) ? 8'd0 : ph + 8'd1;
          if (ph + 8'd1 == 8'(B2 - 1)) pal_r <= (pal_r == 3'd6) ? 3'd0 : pal_r + 3'd1;
        end
      endcase
    end
  end

endmodule

[hw/rtl/led_strip_effect_renderer_core.sv]
// ----------------------------------------------------------------------------
// led_strip_effect_renderer_core
// tick counter and per-pixel effect renderer for an addressable led strip
// ----------------------------------------------------------------------------
// channel  | ports                               | role
// in       | in_valid in_stall in_paused         | one system tick per word
// out      | out_valid out_stall pixel/rgb/end   | one pixel colour per word
// cfg      | cfg_valid cfg_ready cfg_index/data  | register writes
//
// a rendering tick emits NUM_PIXELS words, one per cycle when not stalled,
// then advances the phase in a separate state after the last word.
// a tick that does not render is accepted without emitting words.
// rst_n is synchronous; phases and tick count clear, effect 1, refresh 3.
// out_stall holds the current pixel; in_stall is high while a frame is out.
module led_strip_effect_renderer_core import lser_pkg::*; #(
  parameter int NUM_PIXELS   = 60,
  parameter int BRIGHT_STEPS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_paused,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_pixel_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_frame_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [3:0] effect_r;
  logic [7:0] refresh_r;
  lser_cmd_t  cmd;
  lser_sts_t  sts;
  logic       busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r  <= 4'd1;
      refresh_r <= 8'd3;
    end else if (cfg_valid) begin
      if (cfg_index == REG_EFFECT) effect_r <= cfg_data[3:0];
      else refresh_r <= cfg_data;
    end
  end

  lser_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_paused,
    .refresh_ticks(refresh_r), .out_taken(!out_stall), .out_busy(busy),
    .cmd, .sts
  );

  lser_dp #(.NUM_PIXELS(NUM_PIXELS), .BRIGHT_STEPS(BRIGHT_STEPS)) u_dp (
    .clk, .rst_n, .effect_sel(effect_r), .cmd, .sts,
    .pixel_index(out_pixel_index), .red(out_red), .green(out_green), .blue(out_blue)
  );

  assign out_valid     = busy;
  assign out_frame_end = sts.last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("tick taken during frame");
  a_end_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_pixel_index == 6'd0)
    else $error("frame end off pixel 0");
  a_start_idx: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_pixel_index == 6'(NUM_PIXELS - 1))
    else $error("frame did not start at top pixel");

endmodule
